[hw/rtl/assert_macros.svh]
// Assertion macros for the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[hw/rtl/psr_pkg.sv]
// Types and constants shared by the pulse interval speed ramp block.
`default_nettype none

package psr_pkg;

   // Widths fixed by the register map and the result fields.
   localparam int CFG_BITS   = 12;
   localparam int SPEED_BITS = 10;
   localparam int CSR_IDX_BITS = 3;
   localparam int RSP_BITS   = 24;

   localparam logic [SPEED_BITS-1:0] SPEED_MAX = SPEED_BITS'(1023);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD_LEFT  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD_RIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_INTERVAL    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_INTERVAL    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT_TICKS   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPEED_LIMIT     = 3'd5;

   // Register values after reset.
   localparam logic [CFG_BITS-1:0]   THRESHOLD_RESET = 12'd3351;
   localparam logic [CFG_BITS-1:0]   MIN_INTERVAL_RESET = 12'd50;
   localparam logic [CFG_BITS-1:0]   MAX_INTERVAL_RESET = 12'd200;
   localparam logic [CFG_BITS-1:0]   TIMEOUT_RESET = 12'd2000;
   localparam logic [SPEED_BITS-1:0] SPEED_LIMIT_RESET = 10'd500;

   // Ramp direction of one channel.
   typedef enum logic [1:0] {
      RAMP_NONE = 2'd0,
      RAMP_UP   = 2'd1,
      RAMP_DOWN = 2'd2
   } ramp_type;

   // Interval and speed settings common to both channels.
   typedef struct packed {
      logic [CFG_BITS-1:0]   min_interval;
      logic [CFG_BITS-1:0]   max_interval;
      logic [CFG_BITS-1:0]   timeout_ticks;
      logic [SPEED_BITS-1:0] speed_limit;
   } cfg_type;

   // What one channel shows after its latest tick.
   typedef struct packed {
      logic                  accel;
      logic                  level;
      logic [SPEED_BITS-1:0] speed;
   } chan_out_type;

endpackage

`default_nettype wire

[hw/rtl/psr_chan.sv]
// One channel: level detection, interval classification and speed ramp.
`default_nettype none

module psr_chan #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [SAMPLE_BITS-1:0]  sample,
   input  wire logic [psr_pkg::CFG_BITS-1:0] threshold,
   input  wire psr_pkg::cfg_type        cfg,
   output psr_pkg::chan_out_type        status
);
   import psr_pkg::*;

   localparam int SW = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
   localparam int CW = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam logic [COUNT_BITS-1:0] CMAX   = {COUNT_BITS{1'b1}};
   localparam logic [CW-1:0]         CMAX_X = CW'(CMAX);

   // Channel state; the level, drive and flag registers also form the result.
   logic                  prev_level_ff, prev_level_in;
   logic [COUNT_BITS-1:0] ticks_ff, ticks_in;
   ramp_type              ramp_ff, ramp_in;
   logic [SPEED_BITS-1:0] drive_ff, drive_in;
   logic                  band_ff, band_in;

   logic                  level;
   logic                  rise;
   logic [COUNT_BITS-1:0] n_inc;
   logic [CW-1:0]         n;
   logic [CW-1:0]         min_x, max_x, to_x;

   assign min_x = CW'(cfg.min_interval);
   assign max_x = CW'(cfg.max_interval);
   assign to_x  = CW'(cfg.timeout_ticks);

   // Next state for one tick.
   always_comb begin
      level = (SW'(sample) >= SW'(threshold));
      rise  = level & ~prev_level_ff;
      n_inc = (ticks_ff != CMAX) ? ticks_ff + 1'b1 : ticks_ff;
      n     = CW'(n_inc);
      ramp_in = ramp_ff;
      band_in = band_ff;

      // Classify the interval on a rising edge of the level.
      if (rise) begin
         if (n >= min_x && n <= max_x) begin
            ramp_in = RAMP_UP;
            band_in = 1'b1;
            n       = '0;
         end else if (n > max_x && n <= to_x) begin
            ramp_in = RAMP_DOWN;
            band_in = 1'b0;
            n       = '0;
         end else if (n > to_x) begin
            n = '0;
         end
      end

      // A count at the timeout saturates and turns the ramp down.
      if (n >= to_x) begin
         n       = (to_x > CMAX_X) ? CMAX_X : to_x;
         ramp_in = RAMP_DOWN;
      end
      ticks_in = n[COUNT_BITS-1:0];

      // Limit and floor of the drive.
      if (drive_ff >= cfg.speed_limit) begin
         ramp_in = RAMP_DOWN;
      end
      if (drive_ff == '0 && ramp_in == RAMP_DOWN) begin
         ramp_in = RAMP_NONE;
      end

      // Move the drive one step in the ramp direction.
      drive_in = drive_ff;
      case (ramp_in)
         RAMP_UP: begin
            if (drive_ff != SPEED_MAX) begin
               drive_in = drive_ff + 1'b1;
            end
         end
         RAMP_DOWN: begin
            drive_in = drive_ff - 1'b1;
         end
         default: begin
            drive_in = drive_ff;
         end
      endcase

      prev_level_in = level;
   end

   // State update, once per tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         ticks_ff      <= '0;
         ramp_ff       <= RAMP_NONE;
         drive_ff      <= '0;
         band_ff       <= 1'b0;
      end else if (step) begin
         prev_level_ff <= prev_level_in;
         ticks_ff      <= ticks_in;
         ramp_ff       <= ramp_in;
         drive_ff      <= drive_in;
         band_ff       <= band_in;
      end
   end

   assign status.speed = drive_ff;
   assign status.level = prev_level_ff;
   assign status.accel = band_ff;

endmodule

`default_nettype wire

[hw/rtl/pulse_interval_speed_ramp.sv]
// Top level of the two-channel pulse interval speed ramp.
//
// Each transfer on the req_ channel is one tick carrying a left and a right sample;
// each tick produces exactly one result on the rsp_ channel with both drive speeds,
// the thresholded levels and the in-band flags after that tick. The block takes one
// tick per clock cycle unless the result is stalled. From request to result a tick
// passes through the input register, then through the per-channel update into the
// channel state, which also serves as the result register. The per-channel state
// update (increment, interval compares, drive step) is the loop through the channel
// state that sets this rate. Configuration writes are always ready and take effect on
// the next tick; they are meant to be issued while no tick is in flight.
`default_nettype none

module pulse_interval_speed_ramp #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 12
) (
   input  wire logic clock,
   input  wire logic reset,
   // Tick input; req_tdata: sample_left, sample_right, zero padding.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   // Result output; rsp_tdata: speed_left, speed_right, level_left, level_right,
   // accel_left, accel_right.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [psr_pkg::RSP_BITS-1:0]              rsp_tdata,
   // Register writes.
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [psr_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [psr_pkg::CFG_BITS-1:0]         csr_data
);
   import psr_pkg::*;

   // Configuration registers.
   logic [CFG_BITS-1:0] thr_left_ff, thr_left_in;
   logic [CFG_BITS-1:0] thr_right_ff, thr_right_in;
   cfg_type             cfg_ff, cfg_in;

   // Pipeline control and input register.
   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] sample_left_ff, sample_right_ff;
   logic                   advance;
   logic                   step;
   logic                   req_xfer;

   chan_out_type           st_left, st_right;

   assign csr_ready = 1'b1;

   // Register write decode; indexes past the map are ignored.
   always_comb begin
      thr_left_in  = thr_left_ff;
      thr_right_in = thr_right_ff;
      cfg_in       = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD_LEFT:  thr_left_in  = csr_data;
            CSR_THRESHOLD_RIGHT: thr_right_in = csr_data;
            CSR_MIN_INTERVAL:    cfg_in.min_interval  = csr_data;
            CSR_MAX_INTERVAL:    cfg_in.max_interval  = csr_data;
            CSR_TIMEOUT_TICKS:   cfg_in.timeout_ticks = csr_data;
            CSR_SPEED_LIMIT:     cfg_in.speed_limit   = csr_data[SPEED_BITS-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_left_ff          <= THRESHOLD_RESET;
         thr_right_ff         <= THRESHOLD_RESET;
         cfg_ff.min_interval  <= MIN_INTERVAL_RESET;
         cfg_ff.max_interval  <= MAX_INTERVAL_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
         cfg_ff.speed_limit   <= SPEED_LIMIT_RESET;
      end else begin
         thr_left_ff  <= thr_left_in;
         thr_right_ff <= thr_right_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Handshake: the state moves when a tick waits in the input register and the result slot is free or being taken.
   assign advance    = ~out_valid_ff | rsp_tready;
   assign step       = in_valid_ff & advance;
   assign req_tready = ~in_valid_ff | advance;
   assign req_xfer   = req_tvalid & req_tready;

   always_comb begin
      in_valid_in  = req_xfer | (in_valid_ff & ~step);
      out_valid_in = step | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register for the samples of an accepted transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_left_ff  <= req_tdata[SAMPLE_BITS-1:0];
         sample_right_ff <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      end
   end

   psr_chan #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_chan_left (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .sample   (sample_left_ff),
      .threshold(thr_left_ff),
      .cfg      (cfg_ff),
      .status   (st_left)
   );

   psr_chan #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_chan_right (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .sample   (sample_right_ff),
      .threshold(thr_right_ff),
      .cfg      (cfg_ff),
      .status   (st_right)
   );

   // Result packing, lowest field first.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {st_right.accel, st_left.accel, st_right.level, st_left.level,
                        st_right.speed, st_left.speed};

endmodule

`default_nettype wire

[hw/rtl/psr_checker.sv]
// Port-level checks of the pulse interval speed ramp and their binding.
`default_nettype none

module psr_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_tready,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [psr_pkg::RSP_BITS-1:0] rsp_tdata
);
   import psr_pkg::*;
`include "assert_macros.svh"

   // A stalled result holds its data.
   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp data changed while stalled")

   // With no result waiting the block always takes a new tick.
   `ASSERT_CLK(a_req_ready, !rsp_tvalid |-> req_tready, "req not ready with empty result slot")

   // Leaving reset the drives are at rest and no result is pending.
   `ASSERT_CLK(a_reset_state, $past(reset) |-> !rsp_tvalid && rsp_tdata[9:0] == 10'd0 && rsp_tdata[19:10] == 10'd0, "state not cleared by reset")

   // The left drive moves by at most one step per cycle.
   `ASSERT_CLK(a_left_step, !$past(reset) |-> rsp_tdata[9:0] == $past(rsp_tdata[9:0]) || rsp_tdata[9:0] == $past(rsp_tdata[9:0]) + 10'd1 || rsp_tdata[9:0] == $past(rsp_tdata[9:0]) - 10'd1, "left speed jumped")

   // The right drive moves by at most one step per cycle.
   `ASSERT_CLK(a_right_step, !$past(reset) |-> rsp_tdata[19:10] == $past(rsp_tdata[19:10]) || rsp_tdata[19:10] == $past(rsp_tdata[19:10]) + 10'd1 || rsp_tdata[19:10] == $past(rsp_tdata[19:10]) - 10'd1, "right speed jumped")

endmodule

bind pulse_interval_speed_ramp psr_checker u_psr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire
